@@ rtl/core/tpga_pkg.sv @@
package tpga_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MAG,
        S_SQ,
        S_SUM,
        S_CHK,
        S_BMUL0,
        S_BMUL1,
        S_BSUM,
        S_ROOT_GO,
        S_ROOT,
        S_BIN,
        S_RD,
        S_MULG,
        S_DIV_GO,
        S_DIV,
        S_ACC,
        S_FIN
    } t_state;

    localparam logic [1:0] REG_SKIP    = 2'd0;
    localparam logic [1:0] REG_CUTOFF  = 2'd1;
    localparam logic [1:0] REG_BINS    = 2'd2;
    localparam logic [1:0] REG_OVERLAP = 2'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PAIR = 1'b1;

    typedef logic signed [47:0] t_acc;
    typedef logic signed [57:0] t_sum;

    localparam t_acc ACC_MAX = {1'b0, {47{1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {47{1'b0}}};

    localparam logic [3:0]         SKIP_RST    = 4'd0;
    localparam logic [23:0]        CUTOFF_RST  = 24'd524288;
    localparam logic [8:0]         BINS_RST    = 9'd32;
    localparam logic [16:0]        BINS_SQ_RST = 17'd1024;
    localparam logic signed [31:0] OVL_RST     = 32'sh7FFF_FFFF;

    localparam logic signed [31:0] CLIP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CLIP_MIN = 32'sh8000_0000;

    function automatic t_acc sat_add(input t_acc a, input t_sum c);
        t_sum s;
        s = t_sum'(a) + c;
        if (s > t_sum'(ACC_MAX)) begin
            return ACC_MAX;
        end else if (s < t_sum'(ACC_MIN)) begin
            return ACC_MIN;
        end
        return s[47:0];
    endfunction

endpackage

@@ rtl/core/tpga_table_ram.sv @@
module tpga_table_ram #(
    parameter int DEPTH  = 131072,
    parameter int ADDR_W = 17
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [31:0]       i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [31:0]       o_rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/tpga_isqrt.sv @@
module tpga_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_val;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [35:0] sh;
    logic [35:0] trial;
    logic        ge;

    always_comb begin
        sh    = {r_rem[33:0], r_val[63:62]};
        trial = {2'b00, r_root, 2'b01};
        ge    = (sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[61:0], 2'b00};
            r_rem  <= ge ? (sh - trial) : sh;
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ rtl/core/tpga_div.sv @@
module tpga_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2:0][63:0] i_dividend,
    input  logic [31:0]      i_divisor,
    output logic             o_done,
    output logic [2:0][63:0] o_quot
);
    logic [2:0][63:0] r_quo;
    logic [2:0][31:0] r_rem;
    logic [31:0]      r_dvs;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [2:0][32:0] t;
    logic [2:0]       ge;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t[i]  = {r_rem[i], r_quo[i][63]};
            ge[i] = (t[i] >= {1'b0, r_dvs});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= ge[i] ? 32'(t[i] - {1'b0, r_dvs}) : t[i][31:0];
                r_quo[i] <= {r_quo[i][62:0], ge[i]};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

@@ rtl/core/tabulated_pair_gradient_accumulator.sv @@
// A table load is written while the block stays idle, so the next item can follow.
// A pair runs through the 32-step root units and the 64-step divider; it ends early
// for the skip type or an axis beyond cutoff (after the magnitude step), beyond
// cutoff by distance (after the distance check) or coincident atoms (after the
// accumulate step). One item is taken at a time; a last pair also waits while an
// earlier result is still held in the result register. Reset (synchronous, active
// low) clears accumulators and flags and restores the configuration defaults; the
// gradient table is not cleared and must be loaded before use.
module tabulated_pair_gradient_accumulator #(
    parameter int NUM_TYPES = 16,
    parameter int BINS      = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic [16:0]        i_table_addr,
    input  logic signed [31:0] i_table_value,
    input  logic [3:0]         i_lig_type,
    input  logic [3:0]         i_rec_type,
    input  logic signed [31:0] i_lig_x,
    input  logic signed [31:0] i_lig_y,
    input  logic signed [31:0] i_lig_z,
    input  logic signed [31:0] i_rec_x,
    input  logic signed [31:0] i_rec_y,
    input  logic signed [31:0] i_rec_z,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_grad_x,
    output logic signed [31:0] o_grad_y,
    output logic signed [31:0] o_grad_z,
    output logic               o_overlap,
    output logic               o_saturated
);
    import tpga_pkg::*;

    localparam int DEPTH  = NUM_TYPES * NUM_TYPES * BINS;
    localparam int ADDR_W = $clog2(DEPTH);

    t_state r_state, n_state;

    logic [3:0]         r_skip;
    logic [23:0]        r_cut;
    logic [16:0]        r_bins_sq;
    logic signed [31:0] r_ovl;
    logic [8:0]         cfg_bins;

    logic signed [32:0] r_d [3];
    logic [23:0]        r_mag [3];
    logic [2:0]         r_dneg;
    logic [3:0]         r_lt, r_rt;
    logic               r_last;
    logic [1:0]         r_cnt;
    logic [47:0]        r_sq [3];
    logic [47:0]        r_cut2;
    logic [49:0]        r_r2;
    logic [40:0]        r_plo, r_phi;
    logic [63:0]        r_rb;
    logic [31:0]        r_gm;
    logic               r_gneg;
    logic [2:0][63:0]   r_pg;
    t_sum               r_c [3];
    t_acc               r_acc [3];
    logic               r_ovl_seen;

    logic               r_ovalid;
    logic signed [31:0] r_gx, r_gy, r_gz;
    logic               r_oovl, r_osat;

    logic [32:0]        mag33 [3];
    logic               far;
    logic [23:0]        mul_a;
    logic [31:0]        mul_b;
    logic [55:0]        mul_p;
    logic               root_go, root_done, div_go, div_done;
    logic [31:0]        root_b, root_r;
    logic [2:0][63:0]   quot;
    logic [15:0]        bin;
    logic               bin_bad;
    logic [ADDR_W-1:0]  raddr;
    logic               re, we;
    logic [31:0]        rdata;
    logic               in_xfer, out_free, load_out;
    logic signed [31:0] clip [3];
    logic [2:0]         clip_hit;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign in_xfer     = i_valid && o_ready;
    assign out_free    = !r_ovalid || i_ready;
    assign we = in_xfer && (i_kind == KIND_LOAD) && (32'(i_table_addr) < DEPTH);

    always_comb begin
        if (i_cfg_data[8:0] == 9'd0) begin
            cfg_bins = 9'd1;
        end else if (i_cfg_data[8:0] > 9'd256) begin
            cfg_bins = 9'd256;
        end else begin
            cfg_bins = i_cfg_data[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip    <= SKIP_RST;
            r_cut     <= CUTOFF_RST;
            r_bins_sq <= BINS_SQ_RST;
            r_ovl     <= OVL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SKIP:    r_skip <= i_cfg_data[3:0];
                REG_CUTOFF:  r_cut  <= i_cfg_data[23:0];
                REG_BINS: begin
                    r_bins_sq <= 17'(18'(cfg_bins) * 18'(cfg_bins));
                end
                REG_OVERLAP: r_ovl  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        far = 1'b0;
        for (int i = 0; i < 3; i++) begin
            mag33[i] = r_d[i][32] ? 33'(-r_d[i]) : 33'(r_d[i]);
            if (mag33[i] > {9'b0, r_cut}) begin
                far = 1'b1;
            end
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                case (r_cnt)
                    2'd0:    mul_a = r_mag[0];
                    2'd1:    mul_a = r_mag[1];
                    2'd2:    mul_a = r_mag[2];
                    default: mul_a = r_cut;
                endcase
                mul_b = {8'b0, mul_a};
            end
            S_BMUL0: begin
                mul_a = r_r2[23:0];
                mul_b = 32'(r_bins_sq);
            end
            S_BMUL1: begin
                mul_a = r_r2[47:24];
                mul_b = 32'(r_bins_sq);
            end
            S_MULG: begin
                case (r_cnt)
                    2'd0:    mul_a = r_mag[0];
                    2'd1:    mul_a = r_mag[1];
                    default: mul_a = r_mag[2];
                endcase
                mul_b = r_gm;
            end
            default: ;
        endcase
    end

    assign mul_p = 56'(mul_a) * 56'(mul_b);

    assign root_go = (r_state == S_ROOT_GO);
    assign div_go  = (r_state == S_DIV_GO);

    tpga_isqrt u_root_bin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_go),
        .i_value (r_rb),
        .o_done  (root_done),
        .o_root  (root_b)
    );

    tpga_isqrt u_root_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_go),
        .i_value ({r_r2[47:0], 16'b0}),
        .o_done  (),
        .o_root  (root_r)
    );

    tpga_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend ({{r_pg[2][55:0], 8'b0}, {r_pg[1][55:0], 8'b0}, {r_pg[0][55:0], 8'b0}}),
        .i_divisor  (root_r),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign bin     = root_b[31:16];
    assign bin_bad = (32'(bin) >= BINS) || (32'(r_lt) >= NUM_TYPES)
                   || (32'(r_rt) >= NUM_TYPES);
    assign raddr   = ADDR_W'((ADDR_W'(r_lt) * ADDR_W'(NUM_TYPES) + ADDR_W'(r_rt))
                   * ADDR_W'(BINS) + ADDR_W'(bin));
    assign re      = (r_state == S_BIN) && !bin_bad;

    tpga_table_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (ADDR_W'(i_table_addr)),
        .i_wdata (i_table_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign load_out = (r_state == S_FIN) && r_last && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_kind == KIND_PAIR)) begin
                    n_state = S_MAG;
                end
            end
            S_MAG:     n_state = ((r_rt == r_skip) || far) ? S_FIN : S_SQ;
            S_SQ:      n_state = (r_cnt == 2'd3) ? S_SUM : S_SQ;
            S_SUM:     n_state = S_CHK;
            S_CHK: begin
                if (r_r2 > 50'(r_cut2)) begin
                    n_state = S_FIN;
                end else if (r_r2 == '0) begin
                    n_state = S_ACC;
                end else begin
                    n_state = S_BMUL0;
                end
            end
            S_BMUL0:   n_state = S_BMUL1;
            S_BMUL1:   n_state = S_BSUM;
            S_BSUM:    n_state = S_ROOT_GO;
            S_ROOT_GO: n_state = S_ROOT;
            S_ROOT:    n_state = root_done ? S_BIN : S_ROOT;
            S_BIN:     n_state = bin_bad ? S_FIN : S_RD;
            S_RD:      n_state = S_MULG;
            S_MULG:    n_state = (r_cnt == 2'd2) ? S_DIV_GO : S_MULG;
            S_DIV_GO:  n_state = S_DIV;
            S_DIV:     n_state = div_done ? S_ACC : S_DIV;
            S_ACC:     n_state = S_FIN;
            S_FIN: begin
                if (!r_last || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_d[0] <= 33'(i_lig_x) - 33'(i_rec_x);
                r_d[1] <= 33'(i_lig_y) - 33'(i_rec_y);
                r_d[2] <= 33'(i_lig_z) - 33'(i_rec_z);
                r_lt   <= i_lig_type;
                r_rt   <= i_rec_type;
                r_last <= i_last;
            end
            S_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[i]  <= mag33[i][23:0];
                    r_dneg[i] <= r_d[i][32];
                end
                r_cnt <= '0;
            end
            S_SQ: begin
                case (r_cnt)
                    2'd0:    r_sq[0] <= mul_p[47:0];
                    2'd1:    r_sq[1] <= mul_p[47:0];
                    2'd2:    r_sq[2] <= mul_p[47:0];
                    default: r_cut2  <= mul_p[47:0];
                endcase
                r_cnt <= r_cnt + 2'd1;
            end
            S_SUM: r_r2 <= 50'(r_sq[0]) + 50'(r_sq[1]) + 50'(r_sq[2]);
            S_CHK: begin
                for (int i = 0; i < 3; i++) begin
                    r_c[i] <= t_sum'(r_ovl);
                end
            end
            S_BMUL0: r_plo <= mul_p[40:0];
            S_BMUL1: r_phi <= mul_p[40:0];
            S_BSUM:  r_rb  <= 64'({r_phi, 24'b0}) + 64'(r_plo);
            S_RD: begin
                r_gneg <= rdata[31];
                r_gm   <= rdata[31] ? 32'(-rdata) : rdata;
                r_cnt  <= '0;
            end
            S_MULG: begin
                r_pg[r_cnt] <= 64'(mul_p);
                r_cnt       <= r_cnt + 2'd1;
            end
            S_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_c[i] <= (r_dneg[i] != r_gneg) ? -t_sum'({1'b0, quot[i][56:0]})
                                                    : t_sum'({1'b0, quot[i][56:0]});
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= '0;
            end
            r_ovl_seen <= 1'b0;
        end else if (r_state == S_ACC) begin
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= sat_add(r_acc[i], r_c[i]);
            end
            if (r_r2 == '0) begin
                r_ovl_seen <= 1'b1;
            end
        end else if (load_out) begin
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= '0;
            end
            r_ovl_seen <= 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            clip_hit[i] = 1'b1;
            if (r_acc[i] > t_acc'(CLIP_MAX)) begin
                clip[i] = CLIP_MAX;
            end else if (r_acc[i] < t_acc'(CLIP_MIN)) begin
                clip[i] = CLIP_MIN;
            end else begin
                clip[i]     = r_acc[i][31:0];
                clip_hit[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_gx   <= clip[0];
            r_gy   <= clip[1];
            r_gz   <= clip[2];
            r_oovl <= r_ovl_seen;
            r_osat <= |clip_hit;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_grad_x    = r_gx;
    assign o_grad_y    = r_gy;
    assign o_grad_z    = r_gz;
    assign o_overlap   = r_oovl;
    assign o_saturated = r_osat;
endmodule

@@ rtl/core/tpga_checker.sv @@
module tpga_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               i_kind,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_grad_x,
    input logic signed [31:0] o_grad_y,
    input logic signed [31:0] o_grad_z,
    input logic               o_overlap,
    input logic               o_saturated
);
    import tpga_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_grad_x) && $stable(o_overlap))
        else $error("result changed while stalled");

    a_pair_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_kind == KIND_PAIR) |=> !o_ready)
        else $error("ready after pair transfer");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_kind == KIND_LOAD) |=> o_ready)
        else $error("load transfer stalled input");

    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            (o_grad_x == CLIP_MAX) || (o_grad_x == CLIP_MIN) ||
            (o_grad_y == CLIP_MAX) || (o_grad_y == CLIP_MIN) ||
            (o_grad_z == CLIP_MAX) || (o_grad_z == CLIP_MIN))
        else $error("saturated flag without clipped component");
endmodule

bind tabulated_pair_gradient_accumulator tpga_checker u_tpga_checker (.*);

@@ bench/tabulated_pair_gradient_accumulator_tb.sv @@
module tabulated_pair_gradient_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpga_pkg::*;

    localparam int NTYPES      = 16;
    localparam int NBINS       = 512;
    localparam int DEPTH       = NTYPES * NTYPES * NBINS;
    localparam int DRAIN_WAIT  = 160;
    localparam int STALL_LIMIT = 20000;
    localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct {
        logic               kind;
        logic [16:0]        addr;
        logic signed [31:0] tval;
        logic [3:0]         lt;
        logic [3:0]         rt;
        logic signed [31:0] lx, ly, lz, rx, ry, rz;
        logic               last;
    } atom_item_t;

    typedef struct {
        logic signed [31:0] gx, gy, gz;
        logic               ovl;
        logic               sat;
    } grad_result_t;

    typedef struct {
        logic        needs_load;
        logic [16:0] addr;
        longint      c[3];
        logic        ovl;
    } pair_force_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_kind;
    logic [16:0]        i_table_addr;
    logic signed [31:0] i_table_value;
    logic [3:0]         i_lig_type;
    logic [3:0]         i_rec_type;
    logic signed [31:0] i_lig_x, i_lig_y, i_lig_z;
    logic signed [31:0] i_rec_x, i_rec_y, i_rec_z;
    logic               i_last;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_grad_x, o_grad_y, o_grad_z;
    logic               o_overlap;
    logic               o_saturated;

    tabulated_pair_gradient_accumulator #(.NUM_TYPES(NTYPES), .BINS(NBINS)) uut (.*);

    // model state
    logic signed [31:0] grad_table [int];
    longint             sum_x, sum_y, sum_z;
    logic               ovl_seen;
    logic [3:0]         m_skip;
    logic [63:0]        m_cutoff;
    logic [63:0]        m_bins;
    longint             m_ovl_val;

    grad_result_t expected_grads[$];
    int           errors;
    int           items_sent;
    bit           quiet;
    int           idle_cycles;
    int           stall_left;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint sum_sat(longint a, longint c);
        longint s;
        s = a + c;
        if (s > SUM_MAX) return SUM_MAX;
        if (s < SUM_MIN) return SUM_MIN;
        return s;
    endfunction

    function automatic logic signed [31:0] clip32(longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic pair_force_t pair_force(atom_item_t it);
        pair_force_t f;
        longint      d[3];
        logic [63:0] mag[3];
        logic [63:0] r2, bin, r24, q, gm;
        longint      g;
        int          a;
        f.needs_load = 1'b0;
        f.addr = '0;
        f.ovl = 1'b0;
        for (int i = 0; i < 3; i++) f.c[i] = 0;
        if (it.rt == m_skip) return f;
        d[0] = longint'(it.lx) - longint'(it.rx);
        d[1] = longint'(it.ly) - longint'(it.ry);
        d[2] = longint'(it.lz) - longint'(it.rz);
        for (int i = 0; i < 3; i++) begin
            mag[i] = (d[i] < 0) ? -d[i] : d[i];
            if (mag[i] > m_cutoff) return f;
        end
        r2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        if (r2 > m_cutoff * m_cutoff) return f;
        if (r2 == 0) begin
            for (int i = 0; i < 3; i++) f.c[i] = m_ovl_val;
            f.ovl = 1'b1;
            return f;
        end
        bin = int_sqrt(r2 * m_bins * m_bins) >> 16;
        if (bin >= NBINS) return f;
        a = (int'(it.lt) * NTYPES + int'(it.rt)) * NBINS + int'(bin);
        f.addr = a[16:0];
        if (!grad_table.exists(a)) begin
            f.needs_load = 1'b1;
            return f;
        end
        g = longint'(grad_table[a]);
        gm = (g < 0) ? -g : g;
        r24 = int_sqrt(r2 << 16);
        if (r24 == 0) return f;
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * gm * 64'd256) / r24;
            f.c[i] = ((d[i] < 0) != (g < 0)) ? -longint'(q) : longint'(q);
        end
        return f;
    endfunction

    function automatic void accept_item(atom_item_t it);
        pair_force_t  f;
        grad_result_t r;
        logic         sat;
        if (it.kind == KIND_LOAD) begin
            grad_table[int'(it.addr)] = it.tval;
            return;
        end
        f = pair_force(it);
        if (f.needs_load) begin
            $error("stimulus read an unloaded table entry %0d", f.addr);
            errors++;
        end
        sum_x = sum_sat(sum_x, f.c[0]);
        sum_y = sum_sat(sum_y, f.c[1]);
        sum_z = sum_sat(sum_z, f.c[2]);
        if (f.ovl) ovl_seen = 1'b1;
        if (!it.last) return;
        sat = 1'b0;
        r.gx = clip32(sum_x, sat);
        r.gy = clip32(sum_y, sat);
        r.gz = clip32(sum_z, sat);
        r.ovl = ovl_seen;
        r.sat = sat;
        expected_grads.push_back(r);
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        ovl_seen = 1'b0;
    endfunction

    // result side: random stalls, checking, watchdog
    always @(posedge i_clk) begin
        grad_result_t e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                stall_left <= $urandom_range(1, 16) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
            if (o_valid && i_ready) begin
                if (expected_grads.size() == 0) begin
                    $error("result with none expected");
                    errors++;
                end else begin
                    e = expected_grads.pop_front();
                    if (o_grad_x !== e.gx) begin
                        $error("grad_x exp %0d got %0d", e.gx, o_grad_x);
                        errors++;
                    end
                    if (o_grad_y !== e.gy) begin
                        $error("grad_y exp %0d got %0d", e.gy, o_grad_y);
                        errors++;
                    end
                    if (o_grad_z !== e.gz) begin
                        $error("grad_z exp %0d got %0d", e.gz, o_grad_z);
                        errors++;
                    end
                    if (o_overlap !== e.ovl) begin
                        $error("overlap exp %0d got %0d", e.ovl, o_overlap);
                        errors++;
                    end
                    if (o_saturated !== e.sat) begin
                        $error("saturated exp %0d got %0d", e.sat, o_saturated);
                        errors++;
                    end
                end
            end
            if ((o_valid && i_ready) || (i_valid && o_ready) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_item(atom_item_t it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_kind        <= it.kind;
        i_table_addr  <= it.addr;
        i_table_value <= it.tval;
        i_lig_type    <= it.lt;
        i_rec_type    <= it.rt;
        i_lig_x       <= it.lx;
        i_lig_y       <= it.ly;
        i_lig_z       <= it.lz;
        i_rec_x       <= it.rx;
        i_rec_y       <= it.ry;
        i_rec_z       <= it.rz;
        i_last        <= it.last;
        i_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        accept_item(it);
        items_sent++;
    endtask

    task automatic send_load(logic [16:0] addr, logic signed [31:0] val, logic last);
        atom_item_t it;
        it = '{default: '0};
        it.kind = KIND_LOAD;
        it.addr = addr;
        it.tval = val;
        it.lt = $urandom;
        it.rt = $urandom;
        it.lx = $urandom;
        it.ry = $urandom;
        it.last = last;
        send_item(it);
    endtask

    // loads the entry a pair will read first if it was never written
    task automatic send_pair(atom_item_t it);
        pair_force_t f;
        it.kind = KIND_PAIR;
        it.addr = $urandom;
        it.tval = $urandom;
        f = pair_force(it);
        if (f.needs_load) send_load(f.addr, $urandom, $urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_grads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        drain();
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SKIP:    m_skip = data[3:0];
            REG_CUTOFF:  m_cutoff = 64'(data[23:0]);
            REG_BINS: begin
                m_bins = 64'(data[8:0]);
                if (m_bins == 0) m_bins = 1;
                if (m_bins > 256) m_bins = 256;
            end
            default:     m_ovl_val = longint'($signed(data));
        endcase
        @(posedge i_clk);
    endtask

    function automatic atom_item_t make_pair(logic [3:0] lt, logic [3:0] rt,
                                             logic signed [31:0] dx, logic signed [31:0] dy,
                                             logic signed [31:0] dz, logic last);
        atom_item_t it;
        it = '{default: '0};
        it.lt = lt;
        it.rt = rt;
        it.lx = $urandom_range(0, 32'h00FF_FFFF);
        it.ly = -$signed($urandom_range(0, 32'h00FF_FFFF));
        it.lz = $urandom;
        it.rx = it.lx - dx;
        it.ry = it.ly - dy;
        it.rz = it.lz - dz;
        it.last = last;
        return it;
    endfunction

    task automatic test_basic_pairs();
        send_load(17'((3 * NTYPES + 4) * NBINS + 32), 32'sh8000_0000, 1'b1);
        send_load(17'((3 * NTYPES + 5) * NBINS + 16), 32'sh7FFF_FFFF, 1'b0);
        send_pair(make_pair(3, 4, 32'sd65536, 0, 0, 1'b1));
        send_pair(make_pair(3, 5, 0, -32'sd32768, 0, 1'b0));
        send_pair(make_pair(3, 5, 0, 0, 32'sd32768, 1'b0));
        send_pair(make_pair(3, 4, -32'sd65536, 0, 0, 1'b1));
        send_pair(make_pair(7, 9, 32'sd30000, -32'sd40000, 32'sd50000, 1'b1));
        send_load(17'h1FFFF, 32'sh1234_5678, 1'b0);
        send_load(17'h00000, -32'sd1, 1'b1);
        send_pair(make_pair(15, 15, 32'sd40000, 32'sd40000, -32'sd40000, 1'b1));
    endtask

    task automatic test_special_cases();
        atom_item_t it;
        send_pair(make_pair(2, 0, 32'sd1000, 0, 0, 1'b0));
        send_pair(make_pair(2, 0, 0, 0, 0, 1'b1));
        send_pair(make_pair(2, 6, 32'sd524289, 0, 0, 1'b0));
        send_pair(make_pair(2, 6, 32'sd400000, 32'sd400000, 0, 1'b1));
        send_pair(make_pair(2, 6, 0, 0, 0, 1'b0));
        send_pair(make_pair(2, 6, 0, 0, 0, 1'b1));
        it = make_pair(1, 2, 0, 0, 0, 1'b1);
        it.lx = 32'sh7FFF_FFFF;
        it.ly = 32'sh8000_0000;
        it.lz = 32'sh7FFF_FFFF;
        it.rx = 32'sh8000_0000;
        it.ry = 32'sh7FFF_FFFF;
        it.rz = 32'sh8000_0000;
        send_pair(it);
        write_reg(REG_CUTOFF, 32'hFF00_0000 | 32'd16777215);
        write_reg(REG_BINS, 32'd256);
        send_pair(make_pair(4, 4, 32'sd196608, 0, 0, 1'b0));
        send_pair(make_pair(4, 4, 32'sd131071, 0, 0, 1'b1));
    endtask

    task automatic test_register_extremes();
        write_reg(REG_CUTOFF, 32'd0);
        write_reg(REG_OVERLAP, 32'h8000_0000);
        write_reg(REG_SKIP, 32'hFFFF_FFF0 | 32'd15);
        send_pair(make_pair(5, 3, 0, 0, 0, 1'b0));
        send_pair(make_pair(5, 3, 32'sd1, 0, 0, 1'b0));
        send_pair(make_pair(5, 15, 0, 0, 0, 1'b1));
        write_reg(REG_BINS, 32'd0);
        write_reg(REG_CUTOFF, 32'd16777215);
        write_reg(REG_OVERLAP, 32'h7FFF_FFFF);
        send_pair(make_pair(5, 3, 32'sd65536 * 100, 0, 0, 1'b0));
        send_pair(make_pair(5, 3, 0, 0, 0, 1'b1));
        write_reg(REG_BINS, 32'd300);
        send_pair(make_pair(5, 3, 0, 32'sd100, 0, 1'b1));
    endtask

    function automatic logic signed [31:0] rand_offset();
        logic [31:0] lim;
        lim = (m_cutoff > 64'd0) ? 32'(m_cutoff) : 32'd0;
        case ($urandom_range(0, 3))
            0:       lim = lim >> 4;
            1:       lim = lim >> 1;
            default: lim = lim >> 2;
        endcase
        return 32'(($urandom_range(0, 1) ? 1 : -1) * $signed({1'b0, $urandom_range(0, lim)}));
    endfunction

    task automatic random_runs(int n_items);
        atom_item_t it;
        int         stop_at;
        int         run_len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                send_load($urandom, $urandom, $urandom_range(0, 1));
                continue;
            end
            it = '{default: '0};
            it.lt = $urandom;
            it.lx = $urandom_range(0, 1) ? $urandom : $signed($urandom) >>> 8;
            it.ly = $urandom_range(0, 1) ? $urandom : $signed($urandom) >>> 8;
            it.lz = $urandom_range(0, 1) ? $urandom : $signed($urandom) >>> 8;
            run_len = $urandom_range(1, 6);
            for (int k = 0; k < run_len; k++) begin
                it.rt = ($urandom_range(0, 7) == 0) ? m_skip : 4'($urandom);
                case ($urandom_range(0, 9))
                    0: begin
                        it.rx = it.lx;
                        it.ry = it.ly;
                        it.rz = it.lz;
                    end
                    1: begin
                        it.rx = $urandom;
                        it.ry = $urandom;
                        it.rz = $urandom;
                    end
                    default: begin
                        it.rx = it.lx - rand_offset();
                        it.ry = it.ly - rand_offset();
                        it.rz = it.lz - rand_offset();
                    end
                endcase
                // occasionally cut a run short or leave it open
                it.last = (k == run_len - 1) ? ($urandom_range(0, 9) != 0)
                                             : ($urandom_range(0, 19) == 0);
                send_pair(it);
            end
        end
    endtask

    task automatic random_settings();
        write_reg(REG_SKIP, $urandom);
        case ($urandom_range(0, 3))
            0:       write_reg(REG_CUTOFF, 32'd16777215);
            1:       write_reg(REG_CUTOFF, $urandom_range(0, 32'd65536));
            default: write_reg(REG_CUTOFF, $urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       write_reg(REG_BINS, 32'd1);
            1:       write_reg(REG_BINS, 32'd256);
            default: write_reg(REG_BINS, $urandom);
        endcase
        write_reg(REG_OVERLAP, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h000F_FFFF));
    endtask

    task automatic test_random();
        for (int p = 0; p < 4; p++) begin
            random_settings();
            random_runs(90);
            if (p == 1) drain();
        end
        quiet = 1'b1;
        random_runs(40);
    endtask

    initial begin
        errors = 0;
        items_sent = 0;
        quiet = 1'b0;
        stall_left = 0;
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        ovl_seen = 1'b0;
        m_skip = 4'd0;
        m_cutoff = 64'd524288;
        m_bins = 64'd32;
        m_ovl_val = 64'sd2147483647;
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_SKIP;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_kind <= KIND_LOAD;
        i_table_addr <= '0;
        i_table_value <= '0;
        i_lig_type <= '0;
        i_rec_type <= '0;
        i_lig_x <= '0;
        i_lig_y <= '0;
        i_lig_z <= '0;
        i_rec_x <= '0;
        i_rec_y <= '0;
        i_rec_z <= '0;
        i_last <= 1'b0;
        i_ready <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_pairs();
        test_special_cases();
        test_register_extremes();
        test_random();
        drain();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/tpga_pkg.sv
rtl/core/tpga_table_ram.sv
rtl/core/tpga_isqrt.sv
rtl/core/tpga_div.sv
rtl/core/tabulated_pair_gradient_accumulator.sv
rtl/core/tpga_checker.sv
bench/tabulated_pair_gradient_accumulator_tb.sv
